>>> src/can_afrx_pkg.sv
// shared types and constants for the can acceptance filter and receive ring
// no dependencies; imported by every module of the block
package can_afrx_pkg;

   // command codes carried in req_tuser
   localparam logic [1:0] CMD_SEND   = 2'd0;
   localparam logic [1:0] CMD_RECV   = 2'd1;
   localparam logic [1:0] CMD_ADD    = 2'd2;
   localparam logic [1:0] CMD_REMOVE = 2'd3;

   // status codes carried in rsp_tuser
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_ERR   = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   // configuration register indexes
   localparam int         CSR_INDEX_W   = 1;
   localparam logic [0:0] CSR_RX_ENABLE = 1'b0;
   localparam logic [0:0] CSR_MATCH_ONLY = 1'b1;

   localparam logic [31:0] STD_ID_MAX = 32'h0000_07FF;
   localparam logic [31:0] EXT_ID_MAX = 32'h1FFF_FFFF;
   localparam logic [3:0]  DLC_MAX    = 4'd8;

   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 104;

   // input word, msg_id in the lowest bits
   typedef struct packed {
      logic [2:0]  pad;
      logic [3:0]  filter_slot;
      logic        filter_extended;
      logic [28:0] filter_mask;
      logic [28:0] filter_code;
      logic [63:0] msg_data;
      logic [3:0]  msg_dlc;
      logic        msg_rtr;
      logic        msg_extended;
      logic [31:0] msg_id;
   } req_word_type;

   // result word, added_slot in the lowest bits
   typedef struct packed {
      logic [63:0] rx_data;
      logic [3:0]  rx_dlc;
      logic        rx_rtr;
      logic        rx_extended;
      logic [28:0] rx_id;
      logic        frame_stored;
      logic [3:0]  added_slot;
   } rsp_word_type;

   typedef struct packed {
      logic        ext;
      logic [28:0] mask;
      logic [28:0] code;
   } filt_entry_type;

   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  dlc;
      logic        rtr;
      logic        ext;
      logic [28:0] id;
   } ring_entry_type;

endpackage

>>> src/can_acceptance_filter_rx_fifo.sv
// CAN acceptance filter with receive ring. One command is taken at a time on the req
// channel (send, receive, add filter, remove filter) and one result word comes back on
// the rsp channel; the next command is taken while that result waits. After decode, a
// remove, a rejected send and a receive on an empty ring go straight to the output
// state; a receive otherwise waits on the registered ring read, and a send stored
// without filtering passes through the push state. With filter matching on, a send
// scans the filter table one slot per cycle through its registered memory read; an add
// searches the active bits one slot per cycle. A finished command holds for as long as
// the previous result has not been taken. The ring holds RING_DEPTH - 1 frames; a send
// into a full ring is dropped with frame_stored low. No clearing pass follows reset.
module can_acceptance_filter_rx_fifo import can_afrx_pkg::*; #(
   parameter int FILTER_COUNT = 16,
   parameter int RING_DEPTH   = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // msg_id, msg_extended, msg_rtr, msg_dlc, msg_data, filter_code, filter_mask,
   // filter_extended, filter_slot, zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic [1:0]             req_tuser,   // cmd
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // added_slot, frame_stored, rx_id, rx_extended, rx_rtr, rx_dlc, rx_data
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic [1:0]             rsp_tuser,   // status
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic                   csr_wdata
);

   localparam int FW = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;
   localparam int RW = $clog2(RING_DEPTH);
   localparam int SW = ((FW > 4) ? FW : 4) + 1;
   localparam logic [FW-1:0] FLAST = FW'(FILTER_COUNT - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_FSCAN  = 3'd2;
   localparam logic [2:0] S_PUSH   = 3'd3;
   localparam logic [2:0] S_RDWAIT = 3'd4;
   localparam logic [2:0] S_ASCAN  = 3'd5;
   localparam logic [2:0] S_OUT    = 3'd6;

   logic [2:0]     state_ff, state_in;
   logic [1:0]     cmd_ff, cmd_in;
   req_word_type   req_ff, req_in;
   logic           rx_enable_ff, rx_enable_in;
   logic           match_only_ff, match_only_in;
   logic [FW-1:0]  scan_ff, scan_in;
   logic           iss_ff, iss_in;
   logic           chk_vld_ff, chk_vld_in;
   logic [FW-1:0]  chk_idx_ff, chk_idx_in;
   logic [1:0]     status_ff, status_in;
   rsp_word_type   res_ff, res_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   rsp_word_type   rsp_word_ff, rsp_word_in;

   filt_entry_type          filt_rd, filt_wr_entry;
   logic                    filt_wr, filt_clr;
   logic [FILTER_COUNT-1:0] filt_active;
   ring_entry_type          ring_push_entry, ring_pop_entry;
   logic                    ring_push, ring_pop, ring_empty, ring_full;

   logic [31:0]   id_lim;
   logic          frame_ok, filt_hit, slot_in_range;
   logic [SW-1:0] slot_ext, added_ext;
   logic [FW-1:0] slot_idx;

   can_afrx_filter #(
      .FILTER_COUNT(FILTER_COUNT),
      .FW(FW)
   ) u_filter (
      .clock(clock),
      .reset(reset),
      .rd_addr(scan_ff),
      .rd_entry(filt_rd),
      .wr_en(filt_wr),
      .wr_addr(scan_ff),
      .wr_entry(filt_wr_entry),
      .clr_en(filt_clr),
      .clr_addr(slot_idx),
      .active(filt_active)
   );

   can_afrx_ring #(
      .RING_DEPTH(RING_DEPTH),
      .RW(RW)
   ) u_ring (
      .clock(clock),
      .reset(reset),
      .push(ring_push),
      .push_entry(ring_push_entry),
      .pop(ring_pop),
      .pop_entry(ring_pop_entry),
      .empty(ring_empty),
      .full(ring_full)
   );

   always_comb begin
      id_lim   = req_ff.msg_extended ? EXT_ID_MAX : STD_ID_MAX;
      frame_ok = (req_ff.msg_id <= id_lim) && (req_ff.msg_dlc <= DLC_MAX);
      // filt_rd belongs to the slot issued in the previous cycle
      filt_hit = (filt_rd.ext == req_ff.msg_extended) &&
                 (((req_ff.msg_id[28:0] ^ filt_rd.code) & filt_rd.mask) == 29'd0);
      slot_ext      = SW'(req_ff.filter_slot);
      slot_in_range = slot_ext < SW'(FILTER_COUNT);
      slot_idx      = slot_ext[FW-1:0];
      added_ext     = SW'(scan_ff);

      filt_wr_entry.ext  = req_ff.filter_extended;
      filt_wr_entry.mask = req_ff.filter_mask;
      filt_wr_entry.code = req_ff.filter_code;

      ring_push_entry.data = req_ff.msg_data;
      ring_push_entry.dlc  = req_ff.msg_dlc;
      ring_push_entry.rtr  = req_ff.msg_rtr;
      ring_push_entry.ext  = req_ff.msg_extended;
      ring_push_entry.id   = req_ff.msg_id[28:0];
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      req_in        = req_ff;
      scan_in       = scan_ff;
      iss_in        = iss_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      status_in     = status_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_word_in   = rsp_word_ff;
      rx_enable_in  = rx_enable_ff;
      match_only_in = match_only_ff;
      filt_wr       = 1'b0;
      filt_clr      = 1'b0;
      ring_push     = 1'b0;
      ring_pop      = 1'b0;
      req_tready    = (state_ff == S_IDLE);

      if (csr_we) begin
         unique case (csr_index)
            CSR_RX_ENABLE:  rx_enable_in  = csr_wdata;
            CSR_MATCH_ONLY: match_only_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               req_in   = req_word_type'(req_tdata);
               cmd_in   = req_tuser;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_in    = '0;
            status_in = STAT_OK;
            scan_in   = '0;
            unique case (cmd_ff)
               CMD_SEND: begin
                  if (!frame_ok) begin
                     status_in = STAT_ERR;
                     state_in  = S_OUT;
                  end else if (!rx_enable_ff) begin
                     state_in = S_OUT;
                  end else if (match_only_ff) begin
                     iss_in   = 1'b1;
                     state_in = S_FSCAN;
                  end else begin
                     state_in = S_PUSH;
                  end
               end
               CMD_RECV: begin
                  if (ring_empty) begin
                     status_in = STAT_EMPTY;
                     state_in  = S_OUT;
                  end else begin
                     ring_pop = 1'b1;
                     state_in = S_RDWAIT;
                  end
               end
               CMD_ADD: begin
                  state_in = S_ASCAN;
               end
               CMD_REMOVE: begin
                  if (!slot_in_range || !filt_active[slot_idx]) begin
                     status_in = STAT_ERR;
                  end else begin
                     filt_clr = 1'b1;
                  end
                  state_in = S_OUT;
               end
               default: state_in = S_OUT;
            endcase
         end
         S_FSCAN: begin
            // issue one slot read a cycle, compare the slot read last cycle
            chk_vld_in = iss_ff;
            chk_idx_in = scan_ff;
            if (iss_ff) begin
               if (scan_ff == FLAST) begin
                  iss_in = 1'b0;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
            if (chk_vld_ff && filt_active[chk_idx_ff] && filt_hit) begin
               state_in = S_PUSH;
            end else if (chk_vld_ff && chk_idx_ff == FLAST) begin
               state_in = S_OUT;
            end
         end
         S_PUSH: begin
            if (!ring_full) begin
               ring_push           = 1'b1;
               res_in.frame_stored = 1'b1;
            end
            state_in = S_OUT;
         end
         S_RDWAIT: begin
            res_in.rx_data     = ring_pop_entry.data;
            res_in.rx_dlc      = ring_pop_entry.dlc;
            res_in.rx_rtr      = ring_pop_entry.rtr;
            res_in.rx_extended = ring_pop_entry.ext;
            res_in.rx_id       = ring_pop_entry.id;
            state_in           = S_OUT;
         end
         S_ASCAN: begin
            if (!filt_active[scan_ff]) begin
               filt_wr           = 1'b1;
               res_in.added_slot = added_ext[3:0];
               state_in          = S_OUT;
            end else if (scan_ff == FLAST) begin
               status_in = STAT_ERR;
               state_in  = S_OUT;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_word_in   = res_ff;
               rsp_status_in = status_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         iss_ff        <= 1'b0;
         chk_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rx_enable_ff  <= 1'b1;
         match_only_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         iss_ff        <= iss_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         rx_enable_ff  <= rx_enable_in;
         match_only_ff <= match_only_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      req_ff        <= req_in;
      scan_ff       <= scan_in;
      chk_idx_ff    <= chk_idx_in;
      status_ff     <= status_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_status_ff;

   // ring read data is only consumed the cycle after a pop
   a_rdwait_after_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RDWAIT |-> $past(ring_pop))
      else $error("ring read data used without a pop");

endmodule

>>> src/can_afrx_filter.sv
// acceptance filter table: code/mask/type memory with registered read,
// plus per-slot active bits; depends on can_afrx_pkg
module can_afrx_filter import can_afrx_pkg::*; #(
   parameter int FILTER_COUNT = 16,
   parameter int FW = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [FW-1:0]           rd_addr,
   output filt_entry_type          rd_entry,
   input  logic                    wr_en,
   input  logic [FW-1:0]           wr_addr,
   input  filt_entry_type          wr_entry,
   input  logic                    clr_en,
   input  logic [FW-1:0]           clr_addr,
   output logic [FILTER_COUNT-1:0] active
);

   filt_entry_type          filt_mem [FILTER_COUNT];
   filt_entry_type          rd_entry_ff;
   logic [FILTER_COUNT-1:0] active_ff;
   logic [FILTER_COUNT-1:0] active_in;

   always_comb begin
      active_in = active_ff;
      if (wr_en) begin
         active_in[wr_addr] = 1'b1;
      end
      if (clr_en) begin
         active_in[clr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         filt_mem[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= filt_mem[rd_addr];
   end

   assign rd_entry = rd_entry_ff;
   assign active   = active_ff;

   // an add only ever takes a free slot
   a_add_free: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !active_ff[wr_addr])
      else $error("filter add overwrote an active slot");

endmodule

>>> src/can_afrx_ring.sv
// receive ring: frame memory with registered read and head/tail pointers,
// one slot kept free; depends on can_afrx_pkg
module can_afrx_ring import can_afrx_pkg::*; #(
   parameter int RING_DEPTH = 32,
   parameter int RW = 5
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  ring_entry_type push_entry,
   input  logic           pop,
   output ring_entry_type pop_entry,
   output logic           empty,
   output logic           full
);

   localparam logic [RW-1:0] LAST = RW'(RING_DEPTH - 1);

   ring_entry_type ring_mem [RING_DEPTH];
   ring_entry_type pop_entry_ff;
   logic [RW-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [RW-1:0]  head_nx, tail_nx;

   always_comb begin
      head_nx = (head_ff == LAST) ? '0 : head_ff + 1'b1;
      tail_nx = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;
      empty   = (head_ff == tail_ff);
      full    = (head_nx == tail_ff);
      head_in = push ? head_nx : head_ff;
      tail_in = pop ? tail_nx : tail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ring_mem[head_ff] <= push_entry;
      end
      if (pop) begin
         pop_entry_ff <= ring_mem[tail_ff];
      end
   end

   assign pop_entry = pop_entry_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full ring");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from an empty ring");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> !empty)
      else $error("ring empty right after a push");

endmodule

>>> test/can_acceptance_filter_rx_fifo_test.sv
// self-checking testbench for the can acceptance filter with receive ring
// drives command words, predicts every response word and checks it field by field
// depends on can_afrx_pkg and can_acceptance_filter_rx_fifo
module can_acceptance_filter_rx_fifo_test;
   timeunit 1ns;
   timeprecision 1ps;
   import can_afrx_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int FILTER_SLOTS = 16;
   localparam int RING_SLOTS   = 32;

   typedef struct packed {
      logic         wait_drain;   // hold back until every response is in
      logic [1:0]   cmd;
      req_word_type word;
   } cmd_item_type;

   typedef struct packed {
      logic [1:0]   status;
      rsp_word_type word;
   } can_response_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [1:0]             req_tuser = CMD_SEND;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_RX_ENABLE;
   logic                   csr_wdata = 1'b0;

   can_acceptance_filter_rx_fifo #(
      .FILTER_COUNT (FILTER_SLOTS),
      .RING_DEPTH   (RING_SLOTS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // controller state as the testbench sees it
   logic           rx_enable_cfg = 1'b1;
   logic           match_only_cfg = 1'b0;
   logic           filter_on [FILTER_SLOTS] = '{default: 1'b0};
   filt_entry_type filter_table [FILTER_SLOTS];
   ring_entry_type rx_ring [RING_SLOTS];
   int             ring_wr = 0;
   int             ring_rd = 0;

   cmd_item_type     command_queue [$];
   can_response_type owed_responses [$];
   cmd_item_type     in_flight;
   can_response_type owed;
   rsp_word_type     seen;
   logic             offering;
   int               accepted_count = 0;
   int               results_count = 0;
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   int               errors = 0;

   int n_send = 0, n_queued = 0, n_rejected = 0, n_dropped = 0;
   int n_recv = 0, n_empty = 0, n_add = 0, n_add_full = 0, n_remove = 0, n_remove_err = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s differs, got %h, want %h", $realtime, what, got, want);
      errors++;
   endtask

   function automatic can_response_type exec_command(input cmd_item_type c);
      can_response_type r;
      logic [31:0]      limit;
      logic             hit;
      logic             found;
      int               next_wr;
      r = '0;
      r.status = STAT_OK;
      case (c.cmd)
         CMD_SEND: begin
            n_send++;
            limit = c.word.msg_extended ? EXT_ID_MAX : STD_ID_MAX;
            hit = 1'b0;
            for (int i = 0; i < FILTER_SLOTS; i++) begin
               if (filter_on[i] && filter_table[i].ext == c.word.msg_extended &&
                   (c.word.msg_id[28:0] & filter_table[i].mask) ==
                   (filter_table[i].code & filter_table[i].mask))
                  hit = 1'b1;
            end
            if (c.word.msg_id > limit || c.word.msg_dlc > DLC_MAX) begin
               r.status = STAT_ERR;
               n_rejected++;
            end else if (rx_enable_cfg && (!match_only_cfg || hit)) begin
               next_wr = (ring_wr + 1) % RING_SLOTS;
               // one slot stays free, so a full ring drops the frame quietly
               if (next_wr != ring_rd) begin
                  rx_ring[ring_wr].id   = c.word.msg_id[28:0];
                  rx_ring[ring_wr].ext  = c.word.msg_extended;
                  rx_ring[ring_wr].rtr  = c.word.msg_rtr;
                  rx_ring[ring_wr].dlc  = c.word.msg_dlc;
                  rx_ring[ring_wr].data = c.word.msg_data;
                  ring_wr = next_wr;
                  r.word.frame_stored = 1'b1;
                  n_queued++;
               end else begin
                  n_dropped++;
               end
            end
         end
         CMD_RECV: begin
            n_recv++;
            if (ring_wr == ring_rd) begin
               r.status = STAT_EMPTY;
               n_empty++;
            end else begin
               r.word.rx_id       = rx_ring[ring_rd].id;
               r.word.rx_extended = rx_ring[ring_rd].ext;
               r.word.rx_rtr      = rx_ring[ring_rd].rtr;
               r.word.rx_dlc      = rx_ring[ring_rd].dlc;
               r.word.rx_data     = rx_ring[ring_rd].data;
               ring_rd = (ring_rd + 1) % RING_SLOTS;
            end
         end
         CMD_ADD: begin
            n_add++;
            found = 1'b0;
            for (int i = 0; i < FILTER_SLOTS; i++) begin
               if (!found && !filter_on[i]) begin
                  found = 1'b1;
                  filter_on[i] = 1'b1;
                  filter_table[i].code = c.word.filter_code;
                  filter_table[i].mask = c.word.filter_mask;
                  filter_table[i].ext  = c.word.filter_extended;
                  r.word.added_slot = 4'(i);
               end
            end
            if (!found) begin
               r.status = STAT_ERR;
               n_add_full++;
            end
         end
         CMD_REMOVE: begin
            n_remove++;
            if (int'(c.word.filter_slot) >= FILTER_SLOTS || !filter_on[c.word.filter_slot])
            begin
               r.status = STAT_ERR;
               n_remove_err++;
            end else begin
               filter_on[c.word.filter_slot] = 1'b0;
            end
         end
      endcase
      return r;
   endfunction

   // driver: one word offered at a time, prediction made at the accepting edge
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offering = req_tvalid;
         if (req_tvalid && req_tready) begin
            owed_responses.push_back(exec_command(in_flight));
            accepted_count++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (command_queue.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(command_queue[0].wait_drain && accepted_count != results_count)) begin
               in_flight = command_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= in_flight.word;
               req_tuser <= in_flight.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each response word against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_count <= results_count + 1;
            if (owed_responses.size() == 0) begin
               report_mismatch("word with nothing outstanding", rsp_tuser, STAT_OK);
            end else begin
               owed = owed_responses.pop_front();
               seen = rsp_tdata;
               if (rsp_tuser !== owed.status)
                  report_mismatch("status", rsp_tuser, owed.status);
               if (seen.added_slot !== owed.word.added_slot)
                  report_mismatch("added_slot", seen.added_slot, owed.word.added_slot);
               if (seen.frame_stored !== owed.word.frame_stored)
                  report_mismatch("frame_stored", seen.frame_stored, owed.word.frame_stored);
               if (seen.rx_id !== owed.word.rx_id)
                  report_mismatch("rx_id", seen.rx_id, owed.word.rx_id);
               if (seen.rx_extended !== owed.word.rx_extended)
                  report_mismatch("rx_extended", seen.rx_extended, owed.word.rx_extended);
               if (seen.rx_rtr !== owed.word.rx_rtr)
                  report_mismatch("rx_rtr", seen.rx_rtr, owed.word.rx_rtr);
               if (seen.rx_dlc !== owed.word.rx_dlc)
                  report_mismatch("rx_dlc", seen.rx_dlc, owed.word.rx_dlc);
               if (seen.rx_data !== owed.word.rx_data)
                  report_mismatch("rx_data", seen.rx_data, owed.word.rx_data);
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic cmd_item_type send_cmd(input logic [31:0] id, input logic ext,
                                             input logic rtr, input logic [3:0] dlc,
                                             input logic [63:0] data);
      cmd_item_type c;
      c = '0;
      c.cmd = CMD_SEND;
      c.word.msg_id = id;
      c.word.msg_extended = ext;
      c.word.msg_rtr = rtr;
      c.word.msg_dlc = dlc;
      c.word.msg_data = data;
      return c;
   endfunction

   function automatic cmd_item_type recv_cmd();
      cmd_item_type c;
      c = '0;
      c.cmd = CMD_RECV;
      return c;
   endfunction

   function automatic cmd_item_type add_cmd(input logic [28:0] code, input logic [28:0] mask,
                                            input logic ext);
      cmd_item_type c;
      c = '0;
      c.cmd = CMD_ADD;
      c.word.filter_code = code;
      c.word.filter_mask = mask;
      c.word.filter_extended = ext;
      return c;
   endfunction

   function automatic cmd_item_type remove_cmd(input logic [3:0] slot);
      cmd_item_type c;
      c = '0;
      c.cmd = CMD_REMOVE;
      c.word.filter_slot = slot;
      return c;
   endfunction

   // mostly well-formed commands; sends lean on the live filter table so matches happen
   function automatic cmd_item_type random_command(input int p_send, input int p_recv,
                                                   input int p_add);
      cmd_item_type c;
      logic [31:0]  rnd;
      logic [31:0]  rnd_b;
      logic [28:0]  id29;
      int           roll;
      int           pick;
      c = '0;
      rnd = $urandom;
      c.word.msg_id = $urandom;
      c.word.msg_extended = rnd[0];
      c.word.msg_rtr = rnd[1];
      c.word.msg_dlc = rnd[5:2];
      c.word.msg_data = {$urandom, $urandom};
      rnd = $urandom;
      c.word.filter_code = rnd[28:0];
      rnd = $urandom;
      c.word.filter_mask = rnd[28:0];
      c.word.filter_extended = rnd[31];
      c.word.filter_slot = 4'($urandom_range(15));
      roll = $urandom_range(99);
      if (roll < p_send) begin
         c.cmd = CMD_SEND;
         if ($urandom_range(99) < 85) begin
            rnd = $urandom;
            id29 = rnd[28:0];
            pick = $urandom_range(FILTER_SLOTS - 1);
            if (filter_on[pick] && $urandom_range(1) == 1) begin
               c.word.msg_extended = filter_table[pick].ext;
               id29 = (filter_table[pick].code & filter_table[pick].mask) |
                      (id29 & ~filter_table[pick].mask);
            end
            c.word.msg_id = c.word.msg_extended ? {3'b0, id29} : {21'b0, id29[10:0]};
            c.word.msg_dlc = 4'($urandom_range(8));
         end
      end else if (roll < p_send + p_recv) begin
         c.cmd = CMD_RECV;
      end else if (roll < p_send + p_recv + p_add) begin
         c.cmd = CMD_ADD;
         rnd_b = $urandom;
         if (!c.word.filter_extended && rnd_b[0])
            c.word.filter_code = {18'b0, c.word.filter_code[10:0]};
         case (rnd_b[2:1])
            2'd0: c.word.filter_mask = '0;
            2'd1: c.word.filter_mask = '1;
            default: ;
         endcase
      end else begin
         c.cmd = CMD_REMOVE;
         if ($urandom_range(99) < 60) begin
            pick = $urandom_range(FILTER_SLOTS - 1);
            for (int i = 0; i < FILTER_SLOTS; i++) begin
               if (filter_on[(pick + i) % FILTER_SLOTS] && !filter_on[pick])
                  pick = (pick + i) % FILTER_SLOTS;
            end
            c.word.filter_slot = 4'(pick);
         end
      end
      return c;
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (command_queue.size() != 0 || req_tvalid || results_count != accepted_count);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_RX_ENABLE)
         rx_enable_cfg = value;
      else
         match_only_cfg = value;
      @(negedge clock);
   endtask

   task automatic run_phase(input int count, input int p_send, input int p_recv,
                            input int p_add, input int idle_pct, input int stall,
                            input int drain_every);
      cmd_item_type c;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      for (int k = 0; k < count; k++) begin
         do @(negedge clock);
         while (command_queue.size() >= 2);
         c = random_command(p_send, p_recv, p_add);
         c.wait_drain = (drain_every != 0 && k % drain_every == drain_every - 1);
         command_queue.push_back(c);
      end
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: limits of id and dlc, rtr frame, empty ring, filter slot handling
      command_queue.push_back(recv_cmd());
      command_queue.push_back(remove_cmd(4'd0));
      command_queue.push_back(send_cmd(STD_ID_MAX, 1'b0, 1'b0, DLC_MAX, '1));
      command_queue.push_back(send_cmd(STD_ID_MAX + 1, 1'b0, 1'b0, 4'd1, '0));
      command_queue.push_back(send_cmd(EXT_ID_MAX, 1'b1, 1'b1, 4'd0, 64'h0123_4567_89AB_CDEF));
      command_queue.push_back(send_cmd(EXT_ID_MAX + 1, 1'b1, 1'b0, 4'd2, '1));
      command_queue.push_back(send_cmd('1, 1'b1, 1'b1, 4'd8, '1));
      command_queue.push_back(send_cmd('0, 1'b0, 1'b0, 4'd9, '1));
      command_queue.push_back(send_cmd('0, 1'b1, 1'b0, 4'd15, '0));
      command_queue.push_back(send_cmd('0, 1'b0, 1'b0, 4'd0, '0));
      command_queue.push_back(add_cmd('1, '1, 1'b1));
      command_queue.push_back(add_cmd('0, '0, 1'b0));
      command_queue.push_back(remove_cmd(4'd0));
      command_queue.push_back(add_cmd(29'h0000_07FF, 29'h0000_0700, 1'b0));
      command_queue.push_back(remove_cmd(4'd15));
      repeat (4) command_queue.push_back(recv_cmd());
      wait_drained();

      // receive off, filtering on: nothing may enter the ring
      write_csr(CSR_RX_ENABLE, 1'b0);
      write_csr(CSR_MATCH_ONLY, 1'b1);
      run_phase(40, 40, 25, 20, 88, 0, 0);

      // filtering on: table fills up, adds start to fail
      write_csr(CSR_RX_ENABLE, 1'b1);
      run_phase(110, 45, 30, 15, 0, 88, 50);
      run_phase(110, 45, 30, 15, 10, 10, 40);

      // store everything: ring overflows, then gets emptied
      write_csr(CSR_MATCH_ONLY, 1'b0);
      run_phase(170, 75, 15, 5, 0, 0, 0);
      run_phase(80, 20, 70, 5, 88, 0, 0);

      write_csr(CSR_RX_ENABLE, 1'b0);
      run_phase(50, 40, 25, 20, 0, 88, 25);

      stall_pct = 0;
      repeat (FILTER_SLOTS + 8) @(posedge clock);
      if (owed_responses.size() != 0)
         report_mismatch("responses still owed", owed_responses.size(), 0);

      $display("%0d commands: %0d sends (%0d queued, %0d rejected, %0d lost to a full ring)",
               accepted_count, n_send, n_queued, n_rejected, n_dropped);
      $display("%0d receives (%0d empty), %0d adds (%0d table full), %0d removes (%0d refused)",
               n_recv, n_empty, n_add, n_add_full, n_remove, n_remove_err);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> can_acceptance_filter_rx_fifo.f
src/can_afrx_pkg.sv
src/can_afrx_filter.sv
src/can_afrx_ring.sv
src/can_acceptance_filter_rx_fifo.sv
test/can_acceptance_filter_rx_fifo_test.sv
